### sv/rvc_pkg.sv
// rvc_pkg: shared types and constants for the rv32i subset core
// payload structs for the command and response channels, execute result struct
// no dependencies
`default_nettype none

package rvc_pkg;

	// item modes
	localparam logic [1:0] MODE_EXEC  = 2'd0;
	localparam logic [1:0] MODE_WBYTE = 2'd1;
	localparam logic [1:0] MODE_RBYTE = 2'd2;
	localparam logic [1:0] MODE_RREG  = 2'd3;

	// opcodes
	localparam logic [6:0] OP_R     = 7'h33;
	localparam logic [6:0] OP_I     = 7'h13;
	localparam logic [6:0] OP_LOAD  = 7'h03;
	localparam logic [6:0] OP_JAL   = 7'h6F;
	localparam logic [6:0] OP_BR    = 7'h63;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_HALT  = 7'h7F;

	// funct3 / funct7 codes
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [6:0] F7_SUB = 7'h20;

	localparam int NREGS = 32;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] instr;
		logic [9:0]  mem_addr;
		logic [7:0]  byte_data;
		logic [4:0]  reg_index;
	} rvc_cmd_t;

	typedef struct packed {
		logic [31:0] pc;
		logic        halted;
		logic        reg_write;
		logic [4:0]  reg_dest;
		logic [31:0] reg_value;
		logic        store_done;
		logic [9:0]  store_addr;
		logic [31:0] store_value;
		logic [31:0] read_value;
	} rvc_rsp_t;

	// what the execute logic decides for one item
	typedef struct packed {
		logic [31:0] pc;
		logic        halted;
		logic        reg_write;
		logic [4:0]  reg_dest;
		logic [31:0] reg_value;
		logic        load;
		logic        store_done;
		logic [31:0] ea;
		logic [31:0] store_value;
		logic [31:0] read_value;
		logic        bwrite;
		logic        bread;
	} rvc_ex_t;

endpackage

`default_nettype wire

### sv/rvc_ram.sv
// rvc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/rvc_exec.sv
// rvc_exec: decode and execute of one item, purely combinational
// depends on rvc_pkg
`default_nettype none

module rvc_exec (
	input  wire rvc_pkg::rvc_cmd_t cmd,
	input  wire logic [31:0]       pc_in,
	input  wire logic              halt_in,
	input  wire logic [31:0]       opa,
	input  wire logic [31:0]       opb,
	output rvc_pkg::rvc_ex_t       ex
);
	import rvc_pkg::*;

	logic [6:0]  op;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] rhs;
	logic [31:0] res;
	logic [31:0] next_pc;
	logic        has;
	logic        ld;

	// field split and immediates
	assign op    = cmd.instr[6:0];
	assign rd    = cmd.instr[11:7];
	assign f3    = cmd.instr[14:12];
	assign f7    = cmd.instr[31:25];
	assign imm_i = {{20{cmd.instr[31]}}, cmd.instr[31:20]};
	assign imm_s = {{20{cmd.instr[31]}}, cmd.instr[31:25], cmd.instr[11:7]};
	assign imm_b = {{19{cmd.instr[31]}}, cmd.instr[31], cmd.instr[7],
		cmd.instr[30:25], cmd.instr[11:8], 1'b0};
	assign imm_j = {{11{cmd.instr[31]}}, cmd.instr[31], cmd.instr[19:12],
		cmd.instr[20], cmd.instr[30:21], 1'b0};
	assign rhs   = (op == OP_R) ? opb : imm_i;

	// instruction execute
	always_comb begin
		ex      = '0;
		ex.pc   = pc_in;
		ex.halted = halt_in;
		has     = 1'b0;
		ld      = 1'b0;
		res     = '0;
		next_pc = pc_in + 32'd4;
		case (cmd.mode)
			MODE_EXEC: begin
				if (!halt_in) begin
					unique case (op) inside
						OP_HALT: begin
							ex.halted = 1'b1;
							next_pc   = pc_in;
						end
						OP_R, OP_I: begin
							has = 1'b1;
							case (f3)
								F3_ADD: res = (op == OP_R && f7 == F7_SUB) ? opa - rhs : opa + rhs;
								F3_XOR: res = opa ^ rhs;
								F3_OR:  res = opa | rhs;
								F3_AND: res = opa & rhs;
								default: has = 1'b0;
							endcase
						end
						OP_LOAD: begin
							ex.ea = opa + imm_i;
							if (f3 == F3_LW) begin
								has = 1'b1;
								ld  = 1'b1;
							end
						end
						OP_STORE: begin
							ex.ea          = opa + imm_s;
							ex.store_done  = 1'b1;
							ex.store_value = opb;
						end
						OP_JAL: begin
							has     = 1'b1;
							res     = pc_in + 32'd4;
							next_pc = pc_in + imm_j;
						end
						OP_BR: begin
							if ((f3 == F3_BEQ && opa == opb) || (f3 == F3_BNE && opa != opb)) begin
								next_pc = pc_in + imm_b;
							end
						end
						default: ;
					endcase
					ex.pc        = next_pc;
					ex.reg_write = has && (rd != 5'd0);
					ex.reg_dest  = ex.reg_write ? rd : 5'd0;
					ex.load      = ld && ex.reg_write;
					ex.reg_value = (ex.reg_write && !ld) ? res : 32'd0;
				end
			end
			MODE_WBYTE: ex.bwrite = 1'b1;
			MODE_RBYTE: ex.bread = 1'b1;
			MODE_RREG:  ex.read_value = opa;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### sv/rv32i_subset_single_cycle_core.sv
// rv32i_subset_single_cycle_core: top level of the rv32i subset core
// depends on rvc_pkg, rvc_ram, rvc_exec
// flow: command accept, register read into stage 1, then execute and data memory access
// into stage 2 and response; one item per cycle, stalling on rsp_ready and the memory clear
// reset: pc, halt flag and register valid bits clear at once; the data memory is then
// zeroed one row of four bytes per cycle, all DMEM_BYTES/4 rows with cmd_ready low
// DMEM_BYTES must be a power of two
`default_nettype none

module rv32i_subset_single_cycle_core #(
	parameter int DMEM_BYTES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire rvc_pkg::rvc_cmd_t cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rvc_pkg::rvc_rsp_t      rsp
);
	import rvc_pkg::*;

	localparam int AW     = $clog2(DMEM_BYTES);
	localparam int RW     = AW - 2;
	localparam int RDEPTH = DMEM_BYTES / 4;

	typedef struct packed {
		logic        v;
		logic [4:0]  dest;
		logic [31:0] val;
	} wb_t;

	// pipeline and state registers
	logic             valid_s1;
	rvc_cmd_t         cmd_s1;
	logic             va_s1;
	logic             vb_s1;
	logic             valid_s2;
	rvc_rsp_t         rsp_s2;
	logic             load_s2;
	logic             bread_s2;
	logic [1:0]       lane_s2;
	logic [31:0]      pc_q;
	logic             halt_q;
	logic [NREGS-1:0] rf_vld_q;
	wb_t              wb_q;
	logic             clr_busy_q;
	logic [RW-1:0]    clr_row_q;

	logic        accept;
	logic        adv2;
	logic        fire1;
	logic        commit;
	logic [4:0]  ra_in;
	logic [4:0]  ra_s1;
	logic [4:0]  rb_s1;
	logic [31:0] rfa_q;
	logic [31:0] rfb_q;
	logic [31:0] opa;
	logic [31:0] opb;
	rvc_ex_t     ex;
	logic [31:0] ld_word;

	logic [AW-1:0] maddr_w;
	logic [AW-1:0] acc_addr;
	logic [31:0]   maddr_ext;
	logic [31:0]   ea_ext;
	logic [1:0]    lane;
	logic [RW-1:0] row0;
	logic          dm_we [4];
	logic [RW-1:0] dm_waddr [4];
	logic [7:0]    dm_wdata [4];
	logic [RW-1:0] dm_raddr [4];
	logic [7:0]    dm_q [4];

	// handshake and stage movement
	assign adv2      = !valid_s2 || rsp_ready;
	assign cmd_ready = !clr_busy_q && (!valid_s1 || adv2);
	assign accept    = cmd_valid && cmd_ready;
	assign fire1     = valid_s1 && adv2;
	assign rsp_valid = valid_s2;
	assign commit    = valid_s2 && rsp_ready;

	// register file read addresses
	assign ra_in = (cmd.mode == MODE_RREG) ? cmd.reg_index : cmd.instr[19:15];
	assign ra_s1 = (cmd_s1.mode == MODE_RREG) ? cmd_s1.reg_index : cmd_s1.instr[19:15];
	assign rb_s1 = cmd_s1.instr[24:20];

	// register file, one copy per read port
	rvc_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_a (
		.clk   (clk),
		.we    (commit && rsp.reg_write),
		.waddr (rsp.reg_dest),
		.wdata (rsp.reg_value),
		.re    (accept),
		.raddr (ra_in),
		.rdata (rfa_q)
	);

	rvc_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_b (
		.clk   (clk),
		.we    (commit && rsp.reg_write),
		.waddr (rsp.reg_dest),
		.wdata (rsp.reg_value),
		.re    (accept),
		.raddr (cmd.instr[24:20]),
		.rdata (rfb_q)
	);

	// operand bypass: pending write in s2, then last committed write, then ram
	always_comb begin
		if (valid_s2 && rsp.reg_write && rsp.reg_dest == ra_s1) begin
			opa = rsp.reg_value;
		end else if (wb_q.v && wb_q.dest == ra_s1) begin
			opa = wb_q.val;
		end else begin
			opa = va_s1 ? rfa_q : 32'd0;
		end
		if (valid_s2 && rsp.reg_write && rsp.reg_dest == rb_s1) begin
			opb = rsp.reg_value;
		end else if (wb_q.v && wb_q.dest == rb_s1) begin
			opb = wb_q.val;
		end else begin
			opb = vb_s1 ? rfb_q : 32'd0;
		end
	end

	rvc_exec u_exec (
		.cmd     (cmd_s1),
		.pc_in   (pc_q),
		.halt_in (halt_q),
		.opa     (opa),
		.opb     (opb),
		.ex      (ex)
	);

	// data memory address, wrapped to the memory size
	assign maddr_ext = 32'(cmd_s1.mem_addr);
	assign maddr_w   = maddr_ext[AW-1:0];
	assign acc_addr  = (ex.bwrite || ex.bread) ? maddr_w : ex.ea[AW-1:0];
	assign ea_ext    = 32'(ex.ea[AW-1:0]);
	assign lane      = acc_addr[1:0];
	assign row0      = acc_addr[AW-1:2];

	// byte lane banks: bank k holds the bytes whose address is k mod 4
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0] bi;
			bi = 2'(k) - lane;
			dm_raddr[k] = row0 + ((2'(k) < lane) ? RW'(1) : RW'(0));
			if (clr_busy_q) begin
				dm_we[k]    = 1'b1;
				dm_waddr[k] = clr_row_q;
				dm_wdata[k] = 8'd0;
			end else begin
				dm_we[k]    = fire1 && (ex.store_done || (ex.bwrite && 2'(k) == lane));
				dm_waddr[k] = dm_raddr[k];
				dm_wdata[k] = ex.store_done ? ex.store_value[31 - 8 * int'(bi) -: 8]
					: cmd_s1.byte_data;
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank
		rvc_ram #(.WIDTH(8), .DEPTH(RDEPTH)) u_dm (
			.clk   (clk),
			.we    (dm_we[k]),
			.waddr (dm_waddr[k]),
			.wdata (dm_wdata[k]),
			.re    (fire1),
			.raddr (dm_raddr[k]),
			.rdata (dm_q[k])
		);
	end

	// load word assembly, most significant byte first
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ld_word[31 - 8 * i -: 8] = dm_q[lane_s2 + 2'(i)];
		end
	end

	// response payload
	always_comb begin
		rsp = rsp_s2;
		if (load_s2) begin
			rsp.reg_value = ld_word;
		end
		if (bread_s2) begin
			rsp.read_value = 32'(dm_q[lane_s2]);
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			va_s1  <= rf_vld_q[ra_in];
			vb_s1  <= rf_vld_q[cmd.instr[24:20]];
		end
	end

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			rsp_s2.pc          <= ex.pc;
			rsp_s2.halted      <= ex.halted;
			rsp_s2.reg_write   <= ex.reg_write;
			rsp_s2.reg_dest    <= ex.reg_dest;
			rsp_s2.reg_value   <= ex.reg_value;
			rsp_s2.store_done  <= ex.store_done;
			rsp_s2.store_addr  <= ex.store_done ? ea_ext[9:0] : 10'd0;
			rsp_s2.store_value <= ex.store_value;
			rsp_s2.read_value  <= ex.read_value;
			load_s2            <= ex.load;
			bread_s2           <= ex.bread;
			lane_s2            <= lane;
		end
	end

	// architectural state and write-back tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halt_q   <= 1'b0;
			rf_vld_q <= '0;
			wb_q     <= '0;
		end else begin
			if (fire1) begin
				pc_q   <= ex.pc;
				halt_q <= ex.halted;
			end
			if (commit && rsp.reg_write) begin
				rf_vld_q[rsp.reg_dest] <= 1'b1;
				wb_q <= '{v: 1'b1, dest: rsp.reg_dest, val: rsp.reg_value};
			end
		end
	end

	// data memory clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == {RW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// checks
	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !cmd_ready)
		else $error("command taken during memory clear");

	a_halt_freezes_pc: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q && $stable(pc_q))
		else $error("pc moved or halt dropped after halt");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reg_write |-> rsp.reg_dest != 5'd0)
		else $error("write reported to x0");

	a_store_no_regwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.store_done |-> !rsp.reg_write && !load_s2)
		else $error("store also wrote a register");

endmodule

`default_nettype wire

### tb/rv32i_subset_single_cycle_core_tb.sv
// rv32i_subset_single_cycle_core_tb: self-checking bench for the rv32i subset core
// drives command words from a directed table and a random program; predicts each response,
// or takes it typed in; depends on rvc_pkg and rv32i_subset_single_cycle_core

module rv32i_subset_single_cycle_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvc_pkg::*;

	localparam int MEM_BYTES   = 1024;
	localparam int RANDOM_WORDS = 650;
	localparam int HALTED_WORDS = 15;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		rvc_cmd_t cmd;
		bit       typed;
		rvc_rsp_t rsp;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	rvc_cmd_t cmd = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	rvc_rsp_t rsp;

	// architectural state of the core as the bench sees it
	logic [31:0] arch_pc;
	logic [31:0] arch_regs [0:31];
	logic [7:0]  arch_mem [0:MEM_BYTES-1];
	logic        arch_halted;

	stim_row_t   stim_q [$];
	rvc_rsp_t    rsp_due_q [$];
	int unsigned err_count = 0;
	int unsigned rsp_count = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	int unsigned idle_cycles = 0;

	rv32i_subset_single_cycle_core #(.DMEM_BYTES(MEM_BYTES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// instruction encoders
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OP_R};
	endfunction

	function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BR};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	// command words, unused fields random
	function automatic rvc_cmd_t rand_fields();
		rvc_cmd_t c;
		c.mode      = MODE_EXEC;
		c.instr     = $urandom;
		c.mem_addr  = 10'($urandom);
		c.byte_data = 8'($urandom);
		c.reg_index = 5'($urandom);
		return c;
	endfunction

	function automatic rvc_cmd_t exec_cmd(logic [31:0] instr);
		rvc_cmd_t c;
		c = rand_fields();
		c.instr = instr;
		return c;
	endfunction

	function automatic rvc_cmd_t wbyte_cmd(logic [9:0] addr, logic [7:0] data);
		rvc_cmd_t c;
		c = rand_fields();
		c.mode      = MODE_WBYTE;
		c.mem_addr  = addr;
		c.byte_data = data;
		return c;
	endfunction

	function automatic rvc_cmd_t rbyte_cmd(logic [9:0] addr);
		rvc_cmd_t c;
		c = rand_fields();
		c.mode     = MODE_RBYTE;
		c.mem_addr = addr;
		return c;
	endfunction

	function automatic rvc_cmd_t rreg_cmd(logic [4:0] idx);
		rvc_cmd_t c;
		c = rand_fields();
		c.mode      = MODE_RREG;
		c.reg_index = idx;
		return c;
	endfunction

	function automatic rvc_rsp_t typed_rsp(logic [31:0] pc, logic wr, logic [4:0] dest,
			logic [31:0] val, logic [31:0] rdv);
		rvc_rsp_t r;
		r = '0;
		r.pc         = pc;
		r.reg_write  = wr;
		r.reg_dest   = dest;
		r.reg_value  = val;
		r.read_value = rdv;
		return r;
	endfunction

	function automatic stim_row_t drow(rvc_cmd_t c);
		stim_row_t s;
		s.cmd   = c;
		s.typed = 1'b0;
		s.rsp   = '0;
		return s;
	endfunction

	function automatic stim_row_t trow(rvc_cmd_t c, rvc_rsp_t r);
		stim_row_t s;
		s.cmd   = c;
		s.typed = 1'b1;
		s.rsp   = r;
		return s;
	endfunction

	// random program content
	function automatic logic [4:0] rand_reg();
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [4:0] rand_base();
		return ($urandom_range(0, 1) == 0) ? 5'd0 : rand_reg();
	endfunction

	// offsets mostly near the bottom of memory so loads meet earlier stores
	function automatic logic [11:0] rand_offset();
		return ($urandom_range(0, 9) < 6) ? 12'($urandom_range(0, 63)) : 12'($urandom);
	endfunction

	function automatic logic [2:0] rand_alu_f3();
		logic [2:0] pick [4];
		pick = '{F3_ADD, F3_XOR, F3_OR, F3_AND};
		return ($urandom_range(0, 99) < 85) ? pick[$urandom_range(0, 3)] : 3'($urandom);
	endfunction

	function automatic logic [31:0] rand_instr();
		int unsigned r;
		logic [31:0] w;
		logic [6:0]  f7;
		logic [4:0]  rs1;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			w = $urandom;
			if (w[6:0] == OP_HALT)
				w[6:0] = 7'h00;
		end else if (r < 28) begin
			case ($urandom_range(0, 2))
				0: f7 = 7'h00;
				1: f7 = F7_SUB;
				default: f7 = 7'($urandom);
			endcase
			w = enc_r(f7, rand_reg(), rand_reg(), rand_alu_f3(), rand_reg());
		end else if (r < 50) begin
			w = enc_i(OP_I, 12'($urandom), rand_reg(), rand_alu_f3(), rand_reg());
		end else if (r < 63) begin
			w = enc_i(OP_LOAD, rand_offset(), rand_base(),
				($urandom_range(0, 9) < 9) ? F3_LW : 3'($urandom), rand_reg());
		end else if (r < 76) begin
			w = enc_s(rand_offset(), rand_reg(), rand_base(), 3'($urandom));
		end else if (r < 90) begin
			rs1 = rand_reg();
			w = enc_b({12'($urandom), 1'b0},
				($urandom_range(0, 9) < 4) ? rs1 : rand_reg(), rs1,
				($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 1)) : 3'($urandom));
		end else begin
			w = enc_j({20'($urandom), 1'b0}, rand_reg());
		end
		return w;
	endfunction

	function automatic rvc_cmd_t rand_cmd();
		rvc_cmd_t c;
		int unsigned r;
		c = rand_fields();
		r = $urandom_range(0, 99);
		if (r < 10) begin
			c.mode = MODE_WBYTE;
			if ($urandom_range(0, 1) == 0)
				c.mem_addr = 10'($urandom_range(0, 67));
		end else if (r < 20) begin
			c.mode = MODE_RBYTE;
			if ($urandom_range(0, 1) == 0)
				c.mem_addr = 10'($urandom_range(0, 67));
		end else if (r < 30) begin
			c.mode = MODE_RREG;
		end else begin
			c.instr = rand_instr();
		end
		return c;
	endfunction

	// idle lengths: mostly none or short, a few long
	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(13, 40);
	endfunction

	// retires one command word against the architectural state, returns its response
	function automatic rvc_rsp_t retire_item(rvc_cmd_t c);
		rvc_rsp_t    r;
		logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, ea, nxt, res;
		logic [6:0]  op;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [9:0]  addr;
		logic        has;
		r = '0;
		case (c.mode)
			MODE_WBYTE: arch_mem[c.mem_addr] = c.byte_data;
			MODE_RBYTE: r.read_value = {24'h0, arch_mem[c.mem_addr]};
			MODE_RREG:  r.read_value = arch_regs[c.reg_index];
			default: begin
				if (!arch_halted) begin
					ins   = c.instr;
					op    = ins[6:0];
					rd    = ins[11:7];
					f3    = ins[14:12];
					a     = arch_regs[ins[19:15]];
					b     = arch_regs[ins[24:20]];
					imm_i = {{20{ins[31]}}, ins[31:20]};
					imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
					imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
					imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
					nxt   = arch_pc + 32'd4;
					has   = 1'b0;
					res   = '0;
					if (op == OP_HALT) begin
						arch_halted = 1'b1;
						nxt = arch_pc;
					end else if (op == OP_R || op == OP_I) begin
						b = (op == OP_R) ? b : imm_i;
						has = 1'b1;
						case (f3)
							F3_ADD: res = (op == OP_R && ins[31:25] == F7_SUB) ? a - b : a + b;
							F3_XOR: res = a ^ b;
							F3_OR:  res = a | b;
							F3_AND: res = a & b;
							default: has = 1'b0;
						endcase
					end else if (op == OP_LOAD) begin
						// big-endian word, each byte address wraps on its own
						if (f3 == F3_LW) begin
							ea = a + imm_i;
							for (int k = 0; k < 4; k++) begin
								addr = ea[9:0] + 10'(k);
								res = {res[23:0], arch_mem[addr]};
							end
							has = 1'b1;
						end
					end else if (op == OP_STORE) begin
						ea = a + imm_s;
						for (int k = 0; k < 4; k++) begin
							addr = ea[9:0] + 10'(k);
							arch_mem[addr] = b[31-8*k -: 8];
						end
						r.store_done  = 1'b1;
						r.store_addr  = ea[9:0];
						r.store_value = b;
					end else if (op == OP_JAL) begin
						res = arch_pc + 32'd4;
						has = 1'b1;
						nxt = arch_pc + imm_j;
					end else if (op == OP_BR) begin
						if ((f3 == F3_BEQ && a == b) || (f3 == F3_BNE && a != b))
							nxt = arch_pc + imm_b;
					end
					// x0 stays zero
					if (has && rd != 5'd0) begin
						arch_regs[rd] = res;
						r.reg_write = 1'b1;
						r.reg_dest  = rd;
						r.reg_value = res;
					end
					arch_pc = nxt;
				end
			end
		endcase
		r.pc     = arch_pc;
		r.halted = arch_halted;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] response %0d: %s got %h expected %h", $realtime, rsp_count, what,
			got, want);
		err_count++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// command driver, response checker and watchdog
	always @(posedge clk or negedge arst_n) begin
		rvc_rsp_t due;
		logic     took_cmd;
		logic     took_rsp;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
			rsp_ready <= 1'b0;
		end else begin
			took_cmd = cmd_valid && cmd_ready;
			took_rsp = rsp_valid && rsp_ready;

			// accepted command word: predict, or take the typed-in response
			if (took_cmd) begin
				due = retire_item(cmd);
				if (stim_q[0].typed)
					due = stim_q[0].rsp;
				rsp_due_q.push_back(due);
				void'(stim_q.pop_front());
				if (calm_left > 0) begin
					send_gap = 0;
					calm_left--;
				end else begin
					send_gap = pause_len();
					if ($urandom_range(0, 99) < 3)
						calm_left = 40;
				end
			end

			// present the next word once the current one is gone
			if (!cmd_valid || took_cmd) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (stim_q.size() > 0) begin
					cmd_valid <= 1'b1;
					cmd       <= stim_q[0].cmd;
				end else begin
					cmd_valid <= 1'b0;
				end
			end

			// compare the response word with the oldest prediction
			if (took_rsp) begin
				rsp_count++;
				if (rsp_due_q.size() == 0) begin
					report_mismatch("unexpected response, pc", rsp.pc, '0);
				end else begin
					due = rsp_due_q.pop_front();
					check_field("pc", rsp.pc, due.pc);
					check_field("halted", rsp.halted, due.halted);
					check_field("reg_write", rsp.reg_write, due.reg_write);
					check_field("reg_dest", rsp.reg_dest, due.reg_dest);
					check_field("reg_value", rsp.reg_value, due.reg_value);
					check_field("store_done", rsp.store_done, due.store_done);
					check_field("store_addr", rsp.store_addr, due.store_addr);
					check_field("store_value", rsp.store_value, due.store_value);
					check_field("read_value", rsp.read_value, due.read_value);
				end
			end

			// receiver stalls, none during a calm stretch
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (calm_left == 0 && $urandom_range(0, 99) < 25)
					stall_left = pause_len();
			end

			// watchdog on cycles without any handshake
			if (took_cmd || took_rsp)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] timeout: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// stimulus build, reset, end of run
	initial begin
		stim_row_t plan [];
		arch_pc     = '0;
		arch_halted = 1'b0;
		foreach (arch_regs[i])
			arch_regs[i] = '0;
		foreach (arch_mem[i])
			arch_mem[i] = '0;

		// directed table: reset values, extremes, every operation but halt and odd encodings
		plan = '{
			trow(rreg_cmd(5'd0), typed_rsp(32'd0, 1'b0, 5'd0, 32'd0, 32'd0)),
			trow(rreg_cmd(5'd31), typed_rsp(32'd0, 1'b0, 5'd0, 32'd0, 32'd0)),
			trow(wbyte_cmd(10'd1023, 8'hFF), typed_rsp(32'd0, 1'b0, 5'd0, 32'd0, 32'd0)),
			trow(rbyte_cmd(10'd1023), typed_rsp(32'd0, 1'b0, 5'd0, 32'd0, 32'hFF)),
			trow(exec_cmd(enc_i(OP_I, 12'hFFF, 5'd0, F3_ADD, 5'd1)),
				typed_rsp(32'd4, 1'b1, 5'd1, 32'hFFFF_FFFF, 32'd0)),
			trow(exec_cmd(enc_i(OP_I, 12'h7FF, 5'd0, F3_ADD, 5'd2)),
				typed_rsp(32'd8, 1'b1, 5'd2, 32'h7FF, 32'd0)),
			// write to x0 is dropped
			trow(exec_cmd(enc_i(OP_I, 12'h005, 5'd0, F3_ADD, 5'd0)),
				typed_rsp(32'd12, 1'b0, 5'd0, 32'd0, 32'd0)),
			drow(exec_cmd(enc_r(7'h00, 5'd2, 5'd1, F3_ADD, 5'd3))),
			drow(exec_cmd(enc_r(F7_SUB, 5'd1, 5'd2, F3_ADD, 5'd4))),
			// odd funct7 still adds
			drow(exec_cmd(enc_r(7'h7F, 5'd2, 5'd1, F3_ADD, 5'd5))),
			drow(exec_cmd(enc_r(7'h00, 5'd2, 5'd1, F3_XOR, 5'd6))),
			drow(exec_cmd(enc_r(7'h00, 5'd4, 5'd1, F3_OR, 5'd7))),
			drow(exec_cmd(enc_r(7'h00, 5'd4, 5'd1, F3_AND, 5'd8))),
			drow(exec_cmd(enc_i(OP_I, 12'h800, 5'd2, F3_XOR, 5'd9))),
			drow(exec_cmd(enc_i(OP_I, 12'h0F0, 5'd0, F3_OR, 5'd10))),
			drow(exec_cmd(enc_i(OP_I, 12'hFFF, 5'd2, F3_AND, 5'd11))),
			// unlisted funct3 writes nothing
			drow(exec_cmd(enc_r(7'h00, 5'd2, 5'd1, 3'd1, 5'd12))),
			// word straddling the top of memory, nonstandard store funct3
			drow(exec_cmd(enc_s(12'hFFF, 5'd4, 5'd0, 3'd5))),
			drow(exec_cmd(enc_i(OP_LOAD, 12'hFFF, 5'd0, F3_LW, 5'd13))),
			drow(exec_cmd(enc_i(OP_LOAD, 12'h000, 5'd0, 3'd0, 5'd14))),
			drow(exec_cmd(enc_b(13'd8, 5'd1, 5'd1, F3_BEQ))),
			drow(exec_cmd(enc_b(13'h1FF8, 5'd1, 5'd1, F3_BNE))),
			drow(exec_cmd(enc_b(13'd16, 5'd2, 5'd1, 3'd4))),
			drow(exec_cmd(enc_j(21'h1FFFFC, 5'd15))),
			// unknown opcode only advances the pc
			drow(exec_cmd(32'h0000_0000))
		};
		foreach (plan[i])
			stim_q.push_back(plan[i]);

		// random program, then halt and a few words that find the core halted
		repeat (RANDOM_WORDS)
			stim_q.push_back(drow(rand_cmd()));
		plan = new[1];
		plan[0] = drow(rand_fields());
		plan[0].cmd.instr[6:0] = OP_HALT;
		stim_q.push_back(plan[0]);
		repeat (HALTED_WORDS)
			stim_q.push_back(drow(rand_cmd()));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (stim_q.size() != 0 || cmd_valid || rsp_due_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
sv/rvc_pkg.sv
sv/rvc_ram.sv
sv/rvc_exec.sv
sv/rv32i_subset_single_cycle_core.sv
tb/rv32i_subset_single_cycle_core_tb.sv
